[src/rms_row_normalizer_defines.svh]
// Assertion macros shared by the RMS row normalizer RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef RMS_ROW_NORMALIZER_DEFINES_SVH
`define RMS_ROW_NORMALIZER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define RNM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rnm assertion failed");

// The consequent holds in the cycle after the antecedent.
`define RNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rnm assertion failed");

`endif

[src/rnm_pkg.sv]
// Package of the RMS row normalizer: widths, defaults and shared types.
// It depends on nothing; every module but rnm_ram uses it.
`default_nettype none
package rnm_pkg;
  localparam int ROW_MAX_DEF = 64;
  localparam int CNT_W = 7;
  localparam int SUM_W = 40;
  localparam int EPS_W = 24;
  localparam int DAT_W = 16;
  localparam int INV_W = 32;
  localparam int ACC_W = 58;
  localparam int REM_W = 42;
  localparam int ROOT_W = 29;
  localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;

  typedef struct packed {
    logic start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [EPS_W-1:0] eps;
  } root_req_t;

  typedef struct packed {
    logic done;
    logic [INV_W-1:0] inv;
  } root_rsp_t;
endpackage
`default_nettype wire

[src/rms_row_normalizer.sv]
// Top level of the RMS row normalizer: row buffer, square sum, control.
// Depends on rnm_pkg, rnm_ram, rnm_invroot, rnm_scaler and the defines header.
//
// Channel   Handshake              Payload
// in        start / busy           in_x_value, in_scale_value, in_last_in_row
// out       out_valid (strobe)     out_y_value, out_inv_rms, out_last_of_row
// cfg       cfg_valid / cfg_ready  cfg_epsilon
//
// An accepted element is written to the RAM and squared, then added while busy.
// A row end runs the shared divide and root unit, then the row is emitted one
// result per cycle through the RAM read register and the scaler pipeline.
// Reset is synchronous and empties the row; the receiver cannot stall.
`default_nettype none
`include "rms_row_normalizer_defines.svh"
module rms_row_normalizer #(
  parameter int ROW_MAX = rnm_pkg::ROW_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [rnm_pkg::DAT_W-1:0] in_x_value,
  input  wire logic signed [rnm_pkg::DAT_W-1:0] in_scale_value,
  input  wire logic                             in_last_in_row,
  output logic                                  out_valid,
  output logic signed      [rnm_pkg::DAT_W-1:0] out_y_value,
  output logic             [rnm_pkg::INV_W-1:0] out_inv_rms,
  output logic                                  out_last_of_row,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic        [rnm_pkg::EPS_W-1:0] cfg_epsilon
);
  localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam logic [rnm_pkg::CNT_W-1:0] CNT_MAX = rnm_pkg::CNT_W'(ROW_MAX);
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_MATH = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [rnm_pkg::EPS_W-1:0] eps_r;
  logic [rnm_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [rnm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rnm_pkg::CNT_W-1:0] rd_r, rd_nxt;
  logic pend_r, pend_nxt;
  logic end_r, end_nxt;
  logic [31:0] sq_r;
  logic [rnm_pkg::INV_W-1:0] inv_r;
  logic rdv_r, rdlast_r;
  logic accept, rd_en, rd_last;
  logic [2*rnm_pkg::DAT_W-1:0] rdata;
  rnm_pkg::root_req_t req;
  rnm_pkg::root_rsp_t rsp;
  logic s_last;

  assign accept = start && !busy;
  assign busy = (st_r != ST_LOAD) || pend_r;
  assign cfg_ready = 1'b1;
  assign rd_en = (st_r == ST_EMIT);
  assign rd_last = (rd_r + 7'd1) == cnt_r;

  always_comb begin
    st_nxt = st_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    rd_nxt = rd_r;
    pend_nxt = 1'b0;
    end_nxt = end_r;
    req.start = 1'b0;
    req.sum = sum_r;
    req.count = cnt_r;
    req.eps = eps_r;
    case (st_r)
      ST_LOAD: begin
        if (pend_r) begin
          sum_nxt = sum_r + rnm_pkg::SUM_W'(sq_r);
          if (end_r) begin
            st_nxt = ST_MATH;
            end_nxt = 1'b0;
            req.start = 1'b1;
            req.sum = sum_nxt;
          end
        end else if (accept) begin
          pend_nxt = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
          end_nxt = in_last_in_row || (cnt_nxt == CNT_MAX);
        end
      end
      ST_MATH: begin
        if (rsp.done) begin
          st_nxt = ST_EMIT;
          rd_nxt = '0;
        end
      end
      ST_EMIT: begin
        rd_nxt = rd_r + 7'd1;
        if (rd_last) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_valid && out_last_of_row) begin
          st_nxt = ST_LOAD;
          sum_nxt = '0;
          cnt_nxt = '0;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      eps_r <= rnm_pkg::EPS_RESET;
      sum_r <= '0;
      cnt_r <= '0;
      pend_r <= 1'b0;
      end_r <= 1'b0;
      rdv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        eps_r <= cfg_epsilon;
      end
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      end_r <= end_nxt;
      rdv_r <= rd_en;
    end
    rd_r <= rd_nxt;
    rdlast_r <= rd_last;
    sq_r <= 32'(in_x_value * in_x_value);
    if (rsp.done) begin
      inv_r <= rsp.inv;
    end
  end

  rnm_ram #(
    .WIDTH(2 * rnm_pkg::DAT_W),
    .DEPTH(ROW_MAX),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .we(accept),
    .waddr(cnt_r[AW-1:0]),
    .wdata({in_x_value, in_scale_value}),
    .raddr(rd_r[AW-1:0]),
    .rdata(rdata)
  );

  rnm_invroot u_root (
    .clk(clk),
    .rst_n(rst_n),
    .req(req),
    .rsp(rsp)
  );

  rnm_scaler u_scale (
    .clk(clk),
    .rst_n(rst_n),
    .in_v(rdv_r),
    .in_last(rdlast_r),
    .x(rdata[2*rnm_pkg::DAT_W-1:rnm_pkg::DAT_W]),
    .w(rdata[rnm_pkg::DAT_W-1:0]),
    .inv(inv_r),
    .out_v(out_valid),
    .out_last(s_last),
    .y(out_y_value)
  );

  assign out_last_of_row = s_last;
  assign out_inv_rms = inv_r;

  `RNM_ASSERT_SAME(a_out_in_emit, out_valid, (st_r == ST_EMIT) || (st_r == ST_DRAIN))
  `RNM_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX)
  `RNM_ASSERT_NEXT(a_load_pends, accept, pend_r && busy)
  `RNM_ASSERT_SAME(a_done_in_math, rsp.done, st_r == ST_MATH)
endmodule
`default_nettype wire

[src/rnm_ram.sv]
// Generic single-port-write, single-read RAM with a registered read.
// It depends on nothing.
`default_nettype none
module rnm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/rnm_invroot.sv]
// Sequential unit for the inverse RMS: mean by division, epsilon add,
// reciprocal by division and an integer square root. Uses rnm_pkg.
`default_nettype none
module rnm_invroot (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rnm_pkg::root_req_t req,
  output rnm_pkg::root_rsp_t      rsp
);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV1 = 2'd1;
  localparam logic [1:0] PH_DIV2 = 2'd2;
  localparam logic [1:0] PH_SQRT = 2'd3;

  logic [1:0] ph_r, ph_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [rnm_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [rnm_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [rnm_pkg::REM_W-2:0] div_r, div_nxt;
  logic [rnm_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [rnm_pkg::EPS_W-1:0] eps_r, eps_nxt;
  logic done_r, done_nxt;
  logic [rnm_pkg::INV_W-1:0] inv_r, inv_nxt;

  logic [rnm_pkg::REM_W-1:0] dtrial;
  logic [rnm_pkg::REM_W-1:0] strial;
  logic [rnm_pkg::REM_W-1:0] stest;
  logic [rnm_pkg::REM_W-2:0] m_val;
  logic qbit;

  always_comb begin
    dtrial = {rem_r[rnm_pkg::REM_W-2:0], acc_r[rnm_pkg::ACC_W-1]};
    qbit = dtrial >= {1'b0, div_r};
    stest = {rem_r[rnm_pkg::REM_W-3:0], acc_r[rnm_pkg::ACC_W-1:rnm_pkg::ACC_W-2]};
    strial = {{(rnm_pkg::REM_W-rnm_pkg::ROOT_W-2){1'b0}}, root_r, 2'b01};
    m_val = (rnm_pkg::REM_W-1)'({acc_r[rnm_pkg::SUM_W-2:0], qbit})
          + (rnm_pkg::REM_W-1)'(eps_r);
    ph_nxt = ph_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    root_nxt = root_r;
    eps_nxt = eps_r;
    done_nxt = 1'b0;
    inv_nxt = inv_r;
    case (ph_r)
      PH_IDLE: begin
        if (req.start) begin
          ph_nxt = PH_DIV1;
          cnt_nxt = 6'd39;
          acc_nxt = {req.sum, {(rnm_pkg::ACC_W-rnm_pkg::SUM_W){1'b0}}};
          rem_nxt = '0;
          div_nxt = (rnm_pkg::REM_W-1)'(req.count);
          eps_nxt = req.eps;
        end
      end
      PH_DIV1, PH_DIV2: begin
        if (qbit) begin
          rem_nxt = dtrial - {1'b0, div_r};
          acc_nxt = {acc_r[rnm_pkg::ACC_W-2:0], 1'b1};
        end else begin
          rem_nxt = dtrial;
          acc_nxt = {acc_r[rnm_pkg::ACC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          rem_nxt = '0;
          if (ph_r == PH_DIV1) begin
            if (m_val == '0) begin
              ph_nxt = PH_IDLE;
              done_nxt = 1'b1;
              inv_nxt = '1;
            end else begin
              ph_nxt = PH_DIV2;
              cnt_nxt = 6'd57;
              div_nxt = m_val;
              acc_nxt = {2'b01, {(rnm_pkg::ACC_W-2){1'b0}}};
            end
          end else begin
            ph_nxt = PH_SQRT;
            cnt_nxt = 6'd28;
            root_nxt = '0;
          end
        end
      end
      PH_SQRT: begin
        acc_nxt = {acc_r[rnm_pkg::ACC_W-3:0], 2'b00};
        if (stest >= strial) begin
          rem_nxt = stest - strial;
          root_nxt = {root_r[rnm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = stest;
          root_nxt = {root_r[rnm_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          ph_nxt = PH_IDLE;
          done_nxt = 1'b1;
          inv_nxt = rnm_pkg::INV_W'(root_nxt);
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    root_r <= root_nxt;
    eps_r <= eps_nxt;
    inv_r <= inv_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.inv = inv_r;
endmodule
`default_nettype wire

[src/rnm_scaler.sv]
// Four-stage pipeline forming sample * weight * inverse, rounded and
// saturated to Q4.12. Uses rnm_pkg.
`default_nettype none
module rnm_scaler (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_v,
  input  wire logic                             in_last,
  input  wire logic signed [rnm_pkg::DAT_W-1:0] x,
  input  wire logic signed [rnm_pkg::DAT_W-1:0] w,
  input  wire logic        [rnm_pkg::INV_W-1:0] inv,
  output logic                                  out_v,
  output logic                                  out_last,
  output logic signed      [rnm_pkg::DAT_W-1:0] y
);
  logic [2:0] v_r, last_r;
  logic signed [31:0] p1_r;
  logic signed [63:0] p2_r;
  logic neg_r;
  logic [63:0] mag_r;
  logic signed [64:0] p2_full;
  logic [35:0] rnd;
  logic signed [rnm_pkg::DAT_W-1:0] y_nxt;

  always_comb begin
    p2_full = p1_r * $signed({1'b0, inv});
    rnd = 36'((mag_r + 64'd134217728) >> 28);
    if (neg_r) begin
      y_nxt = (rnd > 36'd32768) ? 16'sh8000 : 16'(-rnd);
    end else begin
      y_nxt = (rnd > 36'd32767) ? 16'sh7FFF : 16'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_v <= 1'b0;
    end else begin
      v_r <= {v_r[1:0], in_v};
      out_v <= v_r[2];
    end
    last_r <= {last_r[1:0], in_last};
    out_last <= last_r[2];
    p1_r <= x * w;
    p2_r <= p2_full[63:0];
    neg_r <= p2_r[63];
    mag_r <= p2_r[63] ? 64'(-p2_r) : 64'(p2_r);
    y <= y_nxt;
  end
endmodule
`default_nettype wire
